// File: hw/rtl/vtrs_pkg.sv
// ----------------------------------------------------------------------------
// View tag record scanner package
// Shared types, character codes and item kinds for the record scanner.
// ----------------------------------------------------------------------------
package vtrs_pkg;

  // Characters that steer the parser
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Result item kinds
  localparam logic [1:0] KIND_NAME  = 2'd0;
  localparam logic [1:0] KIND_PARAM = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // Which tag last passed through a letter shared by several tags
  localparam logic [1:0] ORG_SVC = 2'd0;
  localparam logic [1:0] ORG_G   = 2'd1;
  localparam logic [1:0] ORG_O   = 2'd2;
  localparam logic [1:0] ORG_R   = 2'd3;

  // Controller states: tag, field and emission phases
  typedef enum logic [18:0] {
    ST_BEGIN    = 19'h00001,
    ST_SVC      = 19'h00002,
    ST_I        = 19'h00004,
    ST_E        = 19'h00008,
    ST_W        = 19'h00010,
    ST_COLON    = 19'h00020,
    ST_NAME     = 19'h00040,
    ST_SKIP     = 19'h00080,
    ST_PARAM    = 19'h00100,
    ST_NUMBER   = 19'h00200,
    ST_G        = 19'h00400,
    ST_N        = 19'h00800,
    ST_O        = 19'h01000,
    ST_T        = 19'h02000,
    ST_R        = 19'h04000,
    ST_L        = 19'h08000,
    ST_EM_NAME  = 19'h10000,
    ST_EM_PARAM = 19'h20000,
    ST_EM_END   = 19'h40000
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic rec_clear;
    logic name_wr;
    logic param_wr;
    logic num_digit;
    logic num_bad;
    logic emit_start;
    logic emit_name;
    logic emit_param;
    logic emit_end;
    logic sgn;
    logic intg;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic slash;
    logic colon;
    logic quote;
    logic delim;
    logic digit;
    logic let_v;
    logic let_s;
    logic let_c;
    logic let_i;
    logic let_e;
    logic let_w;
    logic let_g;
    logic let_n;
    logic let_o;
    logic let_t;
    logic let_r;
    logic let_l;
    logic rec_ok;
    logic out_free;
    logic name_last;
    logic param_last;
    logic param_empty;
  } status_t;

  // Letter match in either case
  function automatic logic is_letter(input logic [7:0] b, input logic [7:0] lower);
    return (b == lower) || (b == (lower - 8'd32));
  endfunction

endpackage

// File: hw/rtl/vtrs_if.sv
// ----------------------------------------------------------------------------
// View tag record scanner channels
// Valid/ready channels for text bytes in and record items out.
// ----------------------------------------------------------------------------

// Text byte channel
interface vtrs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_data;

  modport source (output valid, output text_byte, output end_of_data, input ready);
  modport sink   (input valid, input text_byte, input end_of_data, output ready);
endinterface

// Record item channel
interface vtrs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  item_kind;
  logic [7:0]  char_code;
  logic [31:0] channel;
  logic        is_signed;
  logic        is_integer;
  logic        last;

  modport source (output valid, output item_kind, output char_code, output channel,
                  output is_signed, output is_integer, output last, input ready);
  modport sink   (input valid, input item_kind, input char_code, input channel,
                  input is_signed, input is_integer, input last, output ready);
endinterface

// File: hw/rtl/vtrs_ctrl.sv
// ----------------------------------------------------------------------------
// View tag record scanner controller
// Tag and field state machine that issues commands to the datapath and
// sequences the emission of a finished record.
// ----------------------------------------------------------------------------
module vtrs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              end_of_data_i,
  output logic              in_ready_o,
  input  vtrs_pkg::status_t status_i,
  output vtrs_pkg::cmd_t    cmd_o
);

  vtrs_pkg::state_e state_q, state_d;
  logic [1:0]       org_q, org_d;
  logic             after_q, after_d;
  logic             pend_q, pend_d;
  logic             sgn_q, sgn_d;
  logic             intg_q, intg_d;
  logic             accept;

  // Input is taken only while parsing
  assign in_ready_o = (state_q != vtrs_pkg::ST_EM_NAME) &&
                      (state_q != vtrs_pkg::ST_EM_PARAM) &&
                      (state_q != vtrs_pkg::ST_EM_END);
  assign accept = in_valid_i && in_ready_o;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    org_d   = org_q;
    after_d = after_q;
    pend_d  = pend_q;
    sgn_d   = sgn_q;
    intg_d  = intg_q;
    cmd_o      = '0;
    cmd_o.sgn  = sgn_q;
    cmd_o.intg = intg_q;

    unique case (state_q)
      vtrs_pkg::ST_EM_NAME: begin
        if (status_i.out_free) begin
          cmd_o.emit_name = 1'b1;
          if (status_i.name_last) begin
            state_d = status_i.param_empty ? vtrs_pkg::ST_EM_END : vtrs_pkg::ST_EM_PARAM;
          end
        end
      end
      vtrs_pkg::ST_EM_PARAM: begin
        if (status_i.out_free) begin
          cmd_o.emit_param = 1'b1;
          if (status_i.param_last) begin
            state_d = vtrs_pkg::ST_EM_END;
          end
        end
      end
      vtrs_pkg::ST_EM_END: begin
        if (status_i.out_free) begin
          cmd_o.emit_end = 1'b1;
          state_d = vtrs_pkg::ST_BEGIN;
        end
      end
      vtrs_pkg::ST_SVC: begin
        if (accept) begin
          if (status_i.let_v) begin
            sgn_d = 1'b0; intg_d = 1'b0; state_d = vtrs_pkg::ST_I;
          end else if (status_i.let_s) begin
            sgn_d = 1'b1; intg_d = 1'b0; state_d = vtrs_pkg::ST_I;
          end else if (status_i.let_c) begin
            sgn_d = 1'b0; intg_d = 1'b1;
            org_d = vtrs_pkg::ORG_SVC; state_d = vtrs_pkg::ST_O;
          end else begin
            state_d = vtrs_pkg::ST_BEGIN;
          end
        end
      end
      vtrs_pkg::ST_I: begin
        if (accept) begin
          if (status_i.let_i) begin
            state_d = sgn_q ? vtrs_pkg::ST_G : vtrs_pkg::ST_E;
          end else begin
            state_d = vtrs_pkg::ST_BEGIN;
          end
        end
      end
      vtrs_pkg::ST_E: begin
        if (accept) begin
          state_d = status_i.let_e ? vtrs_pkg::ST_W : vtrs_pkg::ST_BEGIN;
        end
      end
      vtrs_pkg::ST_W: begin
        if (accept) begin
          state_d = status_i.let_w ? vtrs_pkg::ST_COLON : vtrs_pkg::ST_BEGIN;
        end
      end
      vtrs_pkg::ST_G: begin
        if (accept) begin
          if (status_i.let_g) begin
            state_d = vtrs_pkg::ST_N; org_d = vtrs_pkg::ORG_G;
          end else begin
            state_d = vtrs_pkg::ST_BEGIN;
          end
        end
      end
      vtrs_pkg::ST_N: begin
        if (accept) begin
          if (status_i.let_n) begin
            state_d = (org_q == vtrs_pkg::ORG_G) ? vtrs_pkg::ST_COLON : vtrs_pkg::ST_T;
          end else begin
            state_d = vtrs_pkg::ST_BEGIN;
          end
        end
      end
      vtrs_pkg::ST_O: begin
        if (accept) begin
          if (status_i.let_o) begin
            if (org_q == vtrs_pkg::ORG_R) begin
              state_d = vtrs_pkg::ST_L;
            end else begin
              state_d = vtrs_pkg::ST_N; org_d = vtrs_pkg::ORG_O;
            end
          end else begin
            state_d = vtrs_pkg::ST_BEGIN;
          end
        end
      end
      vtrs_pkg::ST_T: begin
        if (accept) begin
          state_d = status_i.let_t ? vtrs_pkg::ST_R : vtrs_pkg::ST_BEGIN;
        end
      end
      vtrs_pkg::ST_R: begin
        if (accept) begin
          if (status_i.let_r) begin
            state_d = vtrs_pkg::ST_O; org_d = vtrs_pkg::ORG_R;
          end else begin
            state_d = vtrs_pkg::ST_BEGIN;
          end
        end
      end
      vtrs_pkg::ST_L: begin
        if (accept) begin
          state_d = status_i.let_l ? vtrs_pkg::ST_COLON : vtrs_pkg::ST_BEGIN;
        end
      end
      vtrs_pkg::ST_COLON: begin
        if (accept) begin
          if (status_i.colon) begin
            state_d = vtrs_pkg::ST_NAME;
            cmd_o.rec_clear = 1'b1;
            pend_d = 1'b0;
          end else begin
            state_d = vtrs_pkg::ST_BEGIN;
          end
        end
      end
      vtrs_pkg::ST_NAME: begin
        if (accept) begin
          if (status_i.delim) begin
            state_d = vtrs_pkg::ST_SKIP;
            pend_d  = 1'b0;
            after_d = intg_q;
          end else begin
            cmd_o.name_wr = 1'b1;
          end
        end
      end
      vtrs_pkg::ST_SKIP: begin
        if (accept && status_i.quote) begin
          if (pend_q) begin
            pend_d = 1'b0;
          end else begin
            state_d = after_q ? vtrs_pkg::ST_NUMBER : vtrs_pkg::ST_PARAM;
          end
        end
      end
      vtrs_pkg::ST_PARAM: begin
        if (accept) begin
          if (status_i.delim) begin
            state_d = vtrs_pkg::ST_SKIP;
            after_d = 1'b1;
            pend_d  = !status_i.quote;
          end else begin
            cmd_o.param_wr = 1'b1;
          end
        end
      end
      vtrs_pkg::ST_NUMBER: begin
        if (accept) begin
          if (status_i.quote) begin
            if (status_i.rec_ok) begin
              cmd_o.emit_start = 1'b1;
              state_d = vtrs_pkg::ST_EM_NAME;
            end else begin
              state_d = vtrs_pkg::ST_BEGIN;
            end
          end else if (status_i.digit) begin
            cmd_o.num_digit = 1'b1;
          end else begin
            cmd_o.num_bad = 1'b1;
          end
        end
      end
      default: begin
        if (accept) begin
          state_d = status_i.slash ? vtrs_pkg::ST_SVC : vtrs_pkg::ST_BEGIN;
        end
      end
    endcase

    // End of data returns the parser to idle; a record it completes still goes out
    if (accept && end_of_data_i) begin
      org_d   = vtrs_pkg::ORG_SVC;
      after_d = 1'b0;
      pend_d  = 1'b0;
      sgn_d   = 1'b0;
      intg_d  = 1'b0;
      cmd_o.rec_clear = 1'b1;
      if (state_d != vtrs_pkg::ST_EM_NAME) begin
        state_d = vtrs_pkg::ST_BEGIN;
      end
    end
  end

  // Controller registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vtrs_pkg::ST_BEGIN;
      org_q   <= vtrs_pkg::ORG_SVC;
      after_q <= 1'b0;
      pend_q  <= 1'b0;
      sgn_q   <= 1'b0;
      intg_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      org_q   <= org_d;
      after_q <= after_d;
      pend_q  <= pend_d;
      sgn_q   <= sgn_d;
      intg_q  <= intg_d;
    end
  end

endmodule

// File: hw/rtl/vtrs_dp.sv
// ----------------------------------------------------------------------------
// View tag record scanner datapath
// Byte classification, name and parameter stores, channel accumulator and
// the output register that presents record items.
// ----------------------------------------------------------------------------
module vtrs_dp #(
  parameter int TEXT_MAX = 31
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        text_byte_i,
  input  vtrs_pkg::cmd_t    cmd_i,
  output vtrs_pkg::status_t status_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [1:0]        item_kind_o,
  output logic [7:0]        char_code_o,
  output logic [31:0]       channel_o,
  output logic              is_signed_o,
  output logic              is_integer_o,
  output logic              last_o
);

  localparam int LenW = $clog2(TEXT_MAX + 1);
  localparam int IdxW = (TEXT_MAX > 1) ? $clog2(TEXT_MAX) : 1;
  localparam logic [LenW-1:0] LenMax = LenW'(TEXT_MAX);

  logic [7:0]      name_mem [TEXT_MAX];
  logic [7:0]      param_mem [TEXT_MAX];
  logic [LenW-1:0] name_len_q, name_eff_q, param_len_q, param_eff_q;
  logic            name_zero_q, param_zero_q;
  logic [31:0]     acc_q;
  logic            bad_q, seen_q;
  logic [LenW-1:0] em_nl_q, em_pl_q, em_idx_q;
  logic [31:0]     em_chan_q;
  logic            em_sgn_q, em_intg_q;
  logic            ov_q;
  logic [1:0]      kind_q;
  logic [7:0]      char_q;
  logic [31:0]     chan_q;
  logic            sgn_q, intg_q, last_q;
  logic [35:0]     acc_next;
  logic [31:0]     chan_val;
  logic            name_room, param_room;

  // Channel value and room left in the stores
  assign chan_val = (bad_q || !seen_q) ? 32'd0 : acc_q;
  assign acc_next = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {32'd0, text_byte_i[3:0]};
  assign name_room  = name_len_q < LenMax;
  assign param_room = param_len_q < LenMax;

  // Byte classes and record checks
  always_comb begin
    status_o.slash  = text_byte_i == vtrs_pkg::CH_SLASH;
    status_o.colon  = text_byte_i == vtrs_pkg::CH_COLON;
    status_o.quote  = text_byte_i == vtrs_pkg::CH_QUOTE;
    status_o.delim  = (text_byte_i == vtrs_pkg::CH_SPACE) || (text_byte_i == vtrs_pkg::CH_TAB) ||
                      (text_byte_i == vtrs_pkg::CH_LF) || (text_byte_i == vtrs_pkg::CH_CR) ||
                      (text_byte_i == vtrs_pkg::CH_QUOTE);
    status_o.digit  = (text_byte_i >= vtrs_pkg::CH_ZERO) && (text_byte_i <= vtrs_pkg::CH_NINE);
    status_o.let_v  = vtrs_pkg::is_letter(text_byte_i, 8'h76);
    status_o.let_s  = vtrs_pkg::is_letter(text_byte_i, 8'h73);
    status_o.let_c  = vtrs_pkg::is_letter(text_byte_i, 8'h63);
    status_o.let_i  = vtrs_pkg::is_letter(text_byte_i, 8'h69);
    status_o.let_e  = vtrs_pkg::is_letter(text_byte_i, 8'h65);
    status_o.let_w  = vtrs_pkg::is_letter(text_byte_i, 8'h77);
    status_o.let_g  = vtrs_pkg::is_letter(text_byte_i, 8'h67);
    status_o.let_n  = vtrs_pkg::is_letter(text_byte_i, 8'h6E);
    status_o.let_o  = vtrs_pkg::is_letter(text_byte_i, 8'h6F);
    status_o.let_t  = vtrs_pkg::is_letter(text_byte_i, 8'h74);
    status_o.let_r  = vtrs_pkg::is_letter(text_byte_i, 8'h72);
    status_o.let_l  = vtrs_pkg::is_letter(text_byte_i, 8'h6C);
    status_o.rec_ok      = (name_eff_q != '0) && (chan_val != 32'd0);
    status_o.out_free    = !ov_q || out_ready_i;
    status_o.name_last   = em_idx_q == (em_nl_q - LenW'(1));
    status_o.param_last  = em_idx_q == (em_pl_q - LenW'(1));
    status_o.param_empty = em_pl_q == '0;
  end

  // Name and parameter stores
  always_ff @(posedge clk_i) begin
    if (cmd_i.name_wr && name_room) begin
      name_mem[name_len_q[IdxW-1:0]] <= text_byte_i;
    end
    if (cmd_i.param_wr && param_room) begin
      param_mem[param_len_q[IdxW-1:0]] <= text_byte_i;
    end
  end

  // Record capture: lengths, text ends at a zero byte, channel accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_len_q   <= '0;
      name_eff_q   <= '0;
      name_zero_q  <= 1'b0;
      param_len_q  <= '0;
      param_eff_q  <= '0;
      param_zero_q <= 1'b0;
      acc_q        <= '0;
      bad_q        <= 1'b0;
      seen_q       <= 1'b0;
    end else if (cmd_i.rec_clear) begin
      name_len_q   <= '0;
      name_eff_q   <= '0;
      name_zero_q  <= 1'b0;
      param_len_q  <= '0;
      param_eff_q  <= '0;
      param_zero_q <= 1'b0;
      acc_q        <= '0;
      bad_q        <= 1'b0;
      seen_q       <= 1'b0;
    end else begin
      if (cmd_i.name_wr && name_room) begin
        name_len_q <= name_len_q + LenW'(1);
        if (!name_zero_q) begin
          if (text_byte_i == 8'd0) begin
            name_zero_q <= 1'b1;
          end else begin
            name_eff_q <= name_eff_q + LenW'(1);
          end
        end
      end
      if (cmd_i.param_wr && param_room) begin
        param_len_q <= param_len_q + LenW'(1);
        if (!param_zero_q) begin
          if (text_byte_i == 8'd0) begin
            param_zero_q <= 1'b1;
          end else begin
            param_eff_q <= param_eff_q + LenW'(1);
          end
        end
      end
      if (cmd_i.num_digit) begin
        acc_q  <= acc_next[31:0];
        seen_q <= 1'b1;
        if (acc_next[35:32] != 4'd0) begin
          bad_q <= 1'b1;
        end
      end
      if (cmd_i.num_bad) begin
        bad_q <= 1'b1;
      end
    end
  end

  // Emission snapshot and read index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_nl_q   <= '0;
      em_pl_q   <= '0;
      em_idx_q  <= '0;
      em_chan_q <= '0;
      em_sgn_q  <= 1'b0;
      em_intg_q <= 1'b0;
    end else if (cmd_i.emit_start) begin
      em_nl_q   <= name_eff_q;
      em_pl_q   <= param_eff_q;
      em_idx_q  <= '0;
      em_chan_q <= chan_val;
      em_sgn_q  <= cmd_i.sgn;
      em_intg_q <= cmd_i.intg;
    end else if (cmd_i.emit_name) begin
      em_idx_q <= status_o.name_last ? '0 : em_idx_q + LenW'(1);
    end else if (cmd_i.emit_param) begin
      em_idx_q <= em_idx_q + LenW'(1);
    end
  end

  // Output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.emit_name || cmd_i.emit_param || cmd_i.emit_end) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  // Output payload, with the registered store read
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_name) begin
      kind_q <= vtrs_pkg::KIND_NAME;
      char_q <= name_mem[em_idx_q[IdxW-1:0]];
      chan_q <= '0;
      sgn_q  <= em_sgn_q;
      intg_q <= em_intg_q;
      last_q <= 1'b0;
    end else if (cmd_i.emit_param) begin
      kind_q <= vtrs_pkg::KIND_PARAM;
      char_q <= param_mem[em_idx_q[IdxW-1:0]];
      chan_q <= '0;
      sgn_q  <= em_sgn_q;
      intg_q <= em_intg_q;
      last_q <= 1'b0;
    end else if (cmd_i.emit_end) begin
      kind_q <= vtrs_pkg::KIND_END;
      char_q <= '0;
      chan_q <= em_chan_q;
      sgn_q  <= em_sgn_q;
      intg_q <= em_intg_q;
      last_q <= 1'b1;
    end
  end

  assign out_valid_o  = ov_q;
  assign item_kind_o  = kind_q;
  assign char_code_o  = char_q;
  assign channel_o    = chan_q;
  assign is_signed_o  = sgn_q;
  assign is_integer_o = intg_q;
  assign last_o       = last_q;

endmodule

// File: hw/rtl/view_tag_record_scanner.sv
// ----------------------------------------------------------------------------
// View tag record scanner
// Finds /view:, /sign: and /control: records in a text byte stream and
// emits each valid record as name characters, parameter characters and a
// record-end beat carrying the channel number.
// ----------------------------------------------------------------------------
// The scanner takes one text byte per cycle while it parses. When a record
// closes with a non-empty name and a non-zero channel, input stops while the
// emitted name and parameter characters (the stored text up to its first
// zero byte) and the record-end beat go out; the stored characters are read
// out of the name and parameter stores, one beat per cycle through their
// single read port while the output side does not stall. The output is a
// register, so the byte after a record is taken while its last beat still
// waits. No clearing pass follows reset.
module view_tag_record_scanner #(
  parameter int TEXT_MAX = 31
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  vtrs_in_if.sink    in_i,
  vtrs_out_if.source out_o
);

  vtrs_pkg::cmd_t    cmd;
  vtrs_pkg::status_t status;

  // Tag and field controller
  vtrs_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .end_of_data_i (in_i.end_of_data),
    .in_ready_o    (in_i.ready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  // Stores, accumulator and output register
  vtrs_dp #(
    .TEXT_MAX (TEXT_MAX)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .text_byte_i  (in_i.text_byte),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .item_kind_o  (out_o.item_kind),
    .char_code_o  (out_o.char_code),
    .channel_o    (out_o.channel),
    .is_signed_o  (out_o.is_signed),
    .is_integer_o (out_o.is_integer),
    .last_o       (out_o.last)
  );

endmodule

// File: bench/view_tag_record_scanner_test.sv
// ----------------------------------------------------------------------------
// View tag record scanner testbench
// Streams tagged description text into the scanner and checks every record
// beat against a built-in parser. Directed records cover each tag, letter
// case, a tag mismatch, an overlong name, a name cut by a zero byte, the
// largest and a bad channel and end-of-data. Random records with noise
// follow. Both channel sides stall at random, and one long output hold-off
// early in the run fills the block up.
// ----------------------------------------------------------------------------
module view_tag_record_scanner_test;

  localparam int TEXT_MAX       = 31;
  localparam int DRAIN_CYCLES   = 80;
  localparam int TIMEOUT_CYCLES = 500_000;
  localparam int HOLD_CYCLES    = 400;

  // One record beat as seen on the output channel
  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  char_code;
    logic [31:0] channel;
    logic        is_signed;
    logic        is_integer;
    logic        last;
  } scan_item_t;

  // Bytes that end a name or a parameter word
  function automatic bit is_separator(input logic [7:0] b);
    return b == vtrs_pkg::CH_SPACE || b == vtrs_pkg::CH_TAB || b == vtrs_pkg::CH_LF ||
           b == vtrs_pkg::CH_CR || b == vtrs_pkg::CH_QUOTE;
  endfunction

  // Parser copy and queue of the record beats it predicts
  class record_scoreboard;
    vtrs_pkg::state_e phase;
    logic [1:0]  origin;
    bit          after_skip;
    bit          skip_pending;
    bit          sgn;
    bit          intg;
    logic [7:0]  name_text[TEXT_MAX];
    int          name_len;
    logic [7:0]  param_text[TEXT_MAX];
    int          param_len;
    logic [31:0] acc;
    bit          bad;
    bit          seen;
    scan_item_t  expected_q[$];
    int unsigned failures;

    function new();
      clear();
      failures = 0;
    endfunction

    function void clear();
      phase        = vtrs_pkg::ST_BEGIN;
      origin       = vtrs_pkg::ORG_SVC;
      after_skip   = 0;
      skip_pending = 0;
      sgn          = 0;
      intg         = 0;
      name_len     = 0;
      param_len    = 0;
      acc          = '0;
      bad          = 0;
      seen         = 0;
    endfunction

    function bit match_letter(input logic [7:0] b, input logic [7:0] lower);
      return b == lower || b == lower - 8'd32;
    endfunction

    function void push_item(input logic [1:0] kind, input logic [7:0] ch,
                            input logic [31:0] chan, input logic last);
      scan_item_t it;
      it.kind       = kind;
      it.char_code  = ch;
      it.channel    = chan;
      it.is_signed  = sgn;
      it.is_integer = intg;
      it.last       = last;
      expected_q.push_back(it);
    endfunction

    // A record shows up only with a name and a non-zero channel; stored
    // text stops at the first zero byte.
    function void emit_record(input logic [31:0] chan);
      int nl;
      int pl;
      nl = 0;
      while (nl < name_len && name_text[nl] != 8'h00) nl++;
      pl = 0;
      while (pl < param_len && param_text[pl] != 8'h00) pl++;
      if (nl == 0 || chan == 0) return;
      for (int i = 0; i < nl; i++) push_item(vtrs_pkg::KIND_NAME, name_text[i], '0, 1'b0);
      for (int i = 0; i < pl; i++) push_item(vtrs_pkg::KIND_PARAM, param_text[i], '0, 1'b0);
      push_item(vtrs_pkg::KIND_END, 8'h00, chan, 1'b1);
    endfunction

    // Advance the parser by one accepted text byte.
    function void note_byte(input logic [7:0] b, input logic eod);
      logic [63:0] wide;
      case (phase)
        vtrs_pkg::ST_SVC: begin
          if (match_letter(b, "v")) begin
            sgn = 0; intg = 0; phase = vtrs_pkg::ST_I;
          end else if (match_letter(b, "s")) begin
            sgn = 1; intg = 0; phase = vtrs_pkg::ST_I;
          end else if (match_letter(b, "c")) begin
            sgn = 0; intg = 1; origin = vtrs_pkg::ORG_SVC; phase = vtrs_pkg::ST_O;
          end else begin
            phase = vtrs_pkg::ST_BEGIN;
          end
        end
        vtrs_pkg::ST_I: begin
          if (!match_letter(b, "i")) phase = vtrs_pkg::ST_BEGIN;
          else phase = sgn ? vtrs_pkg::ST_G : vtrs_pkg::ST_E;
        end
        vtrs_pkg::ST_E: phase = match_letter(b, "e") ? vtrs_pkg::ST_W : vtrs_pkg::ST_BEGIN;
        vtrs_pkg::ST_W: phase = match_letter(b, "w") ? vtrs_pkg::ST_COLON : vtrs_pkg::ST_BEGIN;
        vtrs_pkg::ST_G: begin
          if (match_letter(b, "g")) begin
            phase = vtrs_pkg::ST_N; origin = vtrs_pkg::ORG_G;
          end else begin
            phase = vtrs_pkg::ST_BEGIN;
          end
        end
        vtrs_pkg::ST_N: begin
          if (match_letter(b, "n")) begin
            phase = (origin == vtrs_pkg::ORG_G) ? vtrs_pkg::ST_COLON : vtrs_pkg::ST_T;
          end else begin
            phase = vtrs_pkg::ST_BEGIN;
          end
        end
        vtrs_pkg::ST_O: begin
          if (!match_letter(b, "o")) begin
            phase = vtrs_pkg::ST_BEGIN;
          end else if (origin == vtrs_pkg::ORG_R) begin
            phase = vtrs_pkg::ST_L;
          end else begin
            phase = vtrs_pkg::ST_N; origin = vtrs_pkg::ORG_O;
          end
        end
        vtrs_pkg::ST_T: phase = match_letter(b, "t") ? vtrs_pkg::ST_R : vtrs_pkg::ST_BEGIN;
        vtrs_pkg::ST_R: begin
          if (match_letter(b, "r")) begin
            phase = vtrs_pkg::ST_O; origin = vtrs_pkg::ORG_R;
          end else begin
            phase = vtrs_pkg::ST_BEGIN;
          end
        end
        vtrs_pkg::ST_L: phase = match_letter(b, "l") ? vtrs_pkg::ST_COLON : vtrs_pkg::ST_BEGIN;
        vtrs_pkg::ST_COLON: begin
          if (b == vtrs_pkg::CH_COLON) begin
            phase        = vtrs_pkg::ST_NAME;
            name_len     = 0;
            param_len    = 0;
            acc          = '0;
            bad          = 0;
            seen         = 0;
            skip_pending = 0;
          end else begin
            phase = vtrs_pkg::ST_BEGIN;
          end
        end
        vtrs_pkg::ST_NAME: begin
          if (is_separator(b)) begin
            phase        = vtrs_pkg::ST_SKIP;
            skip_pending = 0;
            after_skip   = intg;
          end else if (name_len < TEXT_MAX) begin
            name_text[name_len] = b;
            name_len++;
          end
        end
        vtrs_pkg::ST_SKIP: begin
          if (b == vtrs_pkg::CH_QUOTE) begin
            if (skip_pending) skip_pending = 0;
            else phase = after_skip ? vtrs_pkg::ST_NUMBER : vtrs_pkg::ST_PARAM;
          end
        end
        vtrs_pkg::ST_PARAM: begin
          if (is_separator(b)) begin
            phase        = vtrs_pkg::ST_SKIP;
            after_skip   = 1;
            skip_pending = (b != vtrs_pkg::CH_QUOTE);
          end else if (param_len < TEXT_MAX) begin
            param_text[param_len] = b;
            param_len++;
          end
        end
        vtrs_pkg::ST_NUMBER: begin
          if (b == vtrs_pkg::CH_QUOTE) begin
            emit_record((bad || !seen) ? 32'd0 : acc);
            phase = vtrs_pkg::ST_BEGIN;
          end else if (b >= vtrs_pkg::CH_ZERO && b <= vtrs_pkg::CH_NINE) begin
            wide = {32'd0, acc} * 64'd10 + {56'd0, b - vtrs_pkg::CH_ZERO};
            seen = 1;
            if (wide[63:32] != 0) bad = 1;
            acc = wide[31:0];
          end else begin
            bad = 1;
          end
        end
        default: phase = (b == vtrs_pkg::CH_SLASH) ? vtrs_pkg::ST_SVC : vtrs_pkg::ST_BEGIN;
      endcase
      if (eod) clear();
    endfunction

    function string show(input scan_item_t it);
      return $sformatf("kind=%0d char=%02h chan=%0d signed=%0b integer=%0b last=%0b",
                       it.kind, it.char_code, it.channel, it.is_signed, it.is_integer,
                       it.last);
    endfunction

    function void note_failure(input string msg);
      failures++;
      if (failures <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    // Compare one accepted output beat with the oldest prediction.
    function void check_item(input scan_item_t got);
      scan_item_t exp;
      if (expected_q.size() == 0) begin
        note_failure({"beat with nothing predicted: ", show(got)});
        return;
      end
      exp = expected_q.pop_front();
      if (got.kind !== exp.kind || got.char_code !== exp.char_code ||
          got.channel !== exp.channel || got.is_signed !== exp.is_signed ||
          got.is_integer !== exp.is_integer || got.last !== exp.last)
        note_failure({"beat mismatch, expected ", show(exp), " got ", show(got)});
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  vtrs_in_if  in_if ();
  vtrs_out_if out_if ();

  view_tag_record_scanner #(
    .TEXT_MAX(TEXT_MAX)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  record_scoreboard sb;
  logic [7:0]       text_q[$];
  int unsigned      bytes_sent;
  bit               tx_steady;
  bit               rx_steady;
  int               rx_wait;
  bit               hold_output;
  scan_item_t       observed;

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Random printable text byte that never ends a word, now and then any byte
  function automatic logic [7:0] random_text_char();
    logic [7:0] c;
    if ($urandom_range(0, 19) == 0) begin
      do c = 8'($urandom_range(0, 255)); while (is_separator(c));
    end else begin
      do c = 8'($urandom_range(33, 126)); while (c == vtrs_pkg::CH_QUOTE);
    end
    return c;
  endfunction

  task automatic queue_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic queue_byte(input logic [7:0] b);
    text_q.push_back(b);
  endtask

  // A few skipped bytes and then the quote that opens the next field
  task automatic queue_filler();
    logic [7:0] c;
    repeat ($urandom_range(0, 2)) begin
      do c = 8'($urandom_range(32, 126)); while (c == vtrs_pkg::CH_QUOTE);
      text_q.push_back(c);
    end
    text_q.push_back(vtrs_pkg::CH_QUOTE);
  endtask

  // Offer one byte from a falling edge until a rising edge takes it.
  task automatic send_byte(input logic [7:0] b, input logic eod);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid       = 1'b1;
    in_if.text_byte   = b;
    in_if.end_of_data = eod;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    sb.note_byte(b, eod);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Send the queued text; end of data on its last byte and, if asked, at random.
  task automatic send_queued(input bit eod_last, input bit stray_eod);
    logic eod;
    tx_steady = ($urandom_range(0, 3) == 0);
    while (text_q.size() != 0) begin
      eod = (text_q.size() == 1 && eod_last) || (stray_eod && $urandom_range(0, 59) == 0);
      send_byte(text_q.pop_front(), eod);
    end
  endtask

  // Output side: random stalls after each beat, plus the long hold-off.
  initial begin
    out_if.ready = 1'b0;
    rx_wait      = 0;
    rx_steady    = 0;
    forever begin
      @(negedge clk_i);
      if (rx_wait > 0) rx_wait--;
      out_if.ready = rst_ni && !hold_output && rx_wait == 0 ? 1'b1 : 1'b0;
    end
  end

  // Output monitor
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      observed.kind       = out_if.item_kind;
      observed.char_code  = out_if.char_code;
      observed.channel    = out_if.channel;
      observed.is_signed  = out_if.is_signed;
      observed.is_integer = out_if.is_integer;
      observed.last       = out_if.last;
      sb.check_item(observed);
      if ($urandom_range(0, 19) == 0) rx_steady = !rx_steady;
      rx_wait = rx_steady ? 0 : $urandom_range(0, 6) + 1;
    end
  end

  // Long output hold-off early on while text keeps coming, so the input
  // backs up behind the first record.
  initial begin
    hold_output = 1'b0;
    wait (rst_ni === 1'b1);
    repeat (10) @(posedge clk_i);
    hold_output = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_output = 1'b0;
  end

  // Run limit
  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("*** FAILED ***");
    $finish;
  end

  // Main sequence
  initial begin
    string       tag;
    int          tag_kind;
    int          len;
    int          pick;
    logic [7:0]  c;
    logic [7:0]  term;
    logic [7:0]  separators[5];

    separators = '{vtrs_pkg::CH_SPACE, vtrs_pkg::CH_TAB, vtrs_pkg::CH_LF, vtrs_pkg::CH_CR,
                   vtrs_pkg::CH_QUOTE};
    sb           = new();
    bytes_sent   = 0;
    tx_steady    = 0;
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.text_byte   = 8'h00;
    in_if.end_of_data = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // Records of each tag, mixed letter case, the largest channel and a long name
    queue_str("/view:ab 'v' '17'");
    send_queued(0, 0);
    queue_str("/SiGn:S 'm' '4294967295'");
    send_queued(0, 0);
    queue_str("/CONTROL:");
    for (int i = 0; i < 32; i++) queue_byte(8'h61 + 8'(i % 26));
    queue_str(" '1'");
    send_queued(0, 0);

    // A tag mismatch consumes the second slash; a bad channel drops the record
    queue_str("//view:x '5'/control:n '1x'");
    send_queued(0, 0);

    // A zero byte cuts the name short
    queue_str("/view:a");
    queue_byte(8'h00);
    queue_str("b 'p' '2'");
    send_queued(0, 0);

    // End of data in the middle of a record
    queue_str("/view:h 'p");
    send_queued(1, 0);

    // Random records with noise between them
    while (bytes_sent < 150) begin
      repeat ($urandom_range(0, 3)) queue_byte(8'($urandom_range(0, 255)));
      tag_kind = $urandom_range(0, 2);
      case (tag_kind)
        0: tag = "view";
        1: tag = "sign";
        default: tag = "control";
      endcase
      queue_byte(vtrs_pkg::CH_SLASH);
      for (int i = 0; i < tag.len(); i++) begin
        c = tag[i];
        if ($urandom_range(0, 1) == 1) c = c - 8'd32;
        if ($urandom_range(0, 29) == 0) c = 8'($urandom_range(0, 255));
        queue_byte(c);
      end
      queue_byte(($urandom_range(0, 29) == 0) ? 8'($urandom_range(0, 255)) :
                 vtrs_pkg::CH_COLON);

      // Name: mostly short, sometimes empty or past the store
      pick = $urandom_range(0, 15);
      len = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(28, 35) : $urandom_range(1, 6);
      repeat (len) queue_byte(random_text_char());
      queue_byte(separators[$urandom_range(0, 4)]);
      queue_filler();

      // Parameter word for view and sign records
      if (tag_kind != 2) begin
        pick = $urandom_range(0, 15);
        len = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(28, 35) : $urandom_range(1, 6);
        repeat (len) queue_byte(random_text_char());
        term = ($urandom_range(0, 3) != 0) ? vtrs_pkg::CH_QUOTE :
               separators[$urandom_range(0, 3)];
        queue_byte(term);
        if (term != vtrs_pkg::CH_QUOTE) queue_filler();
        queue_filler();
      end

      // Channel number: mostly valid, sometimes zero, empty, bad or too large
      pick = $urandom_range(0, 11);
      case (pick)
        0: queue_str("0");
        1: ;
        2: begin
          repeat ($urandom_range(0, 3))
            queue_byte(vtrs_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
          do c = 8'($urandom_range(0, 255));
          while (c == vtrs_pkg::CH_QUOTE || (c >= vtrs_pkg::CH_ZERO && c <= vtrs_pkg::CH_NINE));
          queue_byte(c);
          repeat ($urandom_range(0, 2))
            queue_byte(vtrs_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        end
        3: begin
          case ($urandom_range(0, 2))
            0: queue_str("4294967295");
            1: queue_str("4294967296");
            default: repeat ($urandom_range(10, 11))
              queue_byte(vtrs_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
          endcase
        end
        default: queue_str($sformatf("%0d", $urandom_range(1, 99999)));
      endcase
      queue_byte(vtrs_pkg::CH_QUOTE);
      send_queued($urandom_range(0, 7) == 0, 1);
    end
    in_if.valid       = 1'b0;
    in_if.end_of_data = 1'b0;

    // Drain the predicted beats, then watch for strays
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/vtrs_pkg.sv
hw/rtl/vtrs_if.sv
hw/rtl/vtrs_ctrl.sv
hw/rtl/vtrs_dp.sv
hw/rtl/view_tag_record_scanner.sv
bench/view_tag_record_scanner_test.sv
